[hdl/rbs_pkg.sv]
// ----------------------------------------------------------------------------
// rbs_pkg: shared types and codes for the reconnect backoff scheduler
// Request, result and register codes plus the beat payload structs.
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int unsigned DELAY_W = 31;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned ADDR_W  = 3;

    localparam logic [DELAY_W-1:0] MIN_RESET = 31'd1000;
    localparam logic [DELAY_W-1:0] MAX_RESET = 31'd60000;

    typedef enum logic [2:0] {
        REQ_SET_EN   = 3'd0,
        REQ_ARM      = 3'd1,
        REQ_DISARM   = 3'd2,
        REQ_TRY      = 3'd3,
        REQ_START    = 3'd4,
        REQ_DONE     = 3'd5
    } t_req_type;

    typedef enum logic [1:0] {
        OUT_COMPLETED = 2'd0,
        OUT_ABORTED   = 2'd1,
        OUT_ERROR     = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_ABORTED = 2'd2,
        ST_FAILED  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CAUSE_NONE     = 3'd0,
        CAUSE_WAIT_ARM = 3'd1,
        CAUSE_OFF      = 3'd2,
        CAUSE_DISARMED = 3'd3,
        CAUSE_STALE    = 3'd4
    } t_cause;

    // Register word index, taken from paddr[2]
    typedef enum logic {
        REG_BACKOFF_MIN = 1'b0,
        REG_BACKOFF_MAX = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [2:0]         req_type;
        logic               enable_on;
        logic [WORD_W-1:0]  security_word;
        logic [WORD_W-1:0]  module_gen;
        logic [WORD_W-1:0]  now_ms;
        logic [1:0]         call_outcome;
        logic               join_ok;
    } t_req;

    typedef struct packed {
        logic               go;
        logic               is_armed;
        logic               in_flight;
        logic [1:0]         status;
        logic [WORD_W-1:0]  security_out;
        logic [DELAY_W-1:0] backoff_now;
        logic [WORD_W-1:0]  next_try_at;
        logic [WORD_W-1:0]  attempt_count;
        logic [WORD_W-1:0]  success_count;
        logic [WORD_W-1:0]  failure_count;
        logic [2:0]         idle_cause;
    } t_rsp;

endpackage

[hdl/rbs_req_if.sv]
// ----------------------------------------------------------------------------
// rbs_req_if: request channel
// Valid/ready channel carrying one scheduler event per beat.
// ----------------------------------------------------------------------------
interface rbs_req_if import rbs_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/rbs_rsp_if.sv]
// ----------------------------------------------------------------------------
// rbs_rsp_if: result channel
// Valid/ready channel carrying one scheduler result per beat.
// ----------------------------------------------------------------------------
interface rbs_rsp_if import rbs_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/reconnect_backoff_scheduler.sv]
// ----------------------------------------------------------------------------
// reconnect_backoff_scheduler: retry timer with exponential backoff
// Tracks enable/arm state, the retry deadline and attempt counters, and
// answers each event beat with one result beat.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           beat contents
//  i_req     in   valid/ready         one event (type, time, generation, ...)
//  o_rsp     out  valid/ready         one result per event
//  APB       in   psel/penable/pwrite backoff_min_ms at 0x0, backoff_max_ms at 0x4
//
//  Each event passes through the input register and then the result
//  register, one beat per cycle sustained while o_rsp is ready. The state
//  update is a single pass of compare, add and doubling logic per event.
//  Reset (i_rst_n low, synchronous) restores the flags, counters and both
//  backoff registers. A stalled result holds its register; the input stage
//  accepts while it is empty or the result register is free or draining.
// ----------------------------------------------------------------------------
module reconnect_backoff_scheduler import rbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rbs_req_if.sink            i_req,
    rbs_rsp_if.source          o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [WORD_W-1:0]  pwdata,
    output logic [WORD_W-1:0]  prdata,
    output logic               pready
);

    // Configuration registers
    logic [DELAY_W-1:0] r_min;
    logic [DELAY_W-1:0] r_max;

    // Scheduler state
    logic               r_enabled,  n_enabled;
    logic               r_armed,    n_armed;
    logic               r_flight,   n_flight;
    logic [WORD_W-1:0]  r_security, n_security;
    logic [WORD_W-1:0]  r_gen,      n_gen;
    logic [WORD_W-1:0]  r_deadline, n_deadline;
    logic [DELAY_W-1:0] r_backoff,  n_backoff;
    logic [WORD_W-1:0]  r_attempts, n_attempts;
    logic [WORD_W-1:0]  r_successes, n_successes;
    logic [WORD_W-1:0]  r_failures, n_failures;
    t_cause             r_cause,    n_cause;

    // Pipeline registers
    logic               r_in_valid;
    t_req               r_req;
    logic               r_out_valid;
    t_rsp               r_rsp;

    logic               in_fire;
    logic               out_free;
    logic               adv;
    logic               go;
    t_status            status;
    logic [WORD_W-1:0]  grown;
    logic [DELAY_W-1:0] capped;
    logic [WORD_W-1:0]  since;
    logic               cfg_wr;

    // ------------------------------------------------------------------
    // APB register port: word index from paddr[2], writes in access phase
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_BACKOFF_MIN: prdata = {1'b0, r_min};
            REG_BACKOFF_MAX: prdata = {1'b0, r_max};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_RESET;
            r_max <= MAX_RESET;
        end else if (cfg_wr) begin
            if (t_reg_idx'(paddr[2]) == REG_BACKOFF_MIN) begin
                r_min <= pwdata[DELAY_W-1:0];
            end else begin
                r_max <= pwdata[DELAY_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake: advance the input register whenever the result register
    // is empty or is handing its beat over in this cycle
    // ------------------------------------------------------------------
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign adv         = r_in_valid && out_free;
    assign i_req.ready = !r_in_valid || out_free;
    assign in_fire     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req <= i_req.payload;
        end
    end

    // ------------------------------------------------------------------
    // Backoff arithmetic: load the minimum from zero, else double; the
    // doubled value is at most 32 bits, so saturate against the maximum
    // ------------------------------------------------------------------
    assign grown  = (r_backoff == '0) ? {1'b0, r_min} : {r_backoff, 1'b0};
    assign capped = (grown > {1'b0, r_max}) ? r_max : grown[DELAY_W-1:0];
    // Wrapping signed compare: deadline reached when the difference is >= 0
    assign since  = r_req.now_ms - r_deadline;

    // ------------------------------------------------------------------
    // Event decode and next state
    // ------------------------------------------------------------------
    always_comb begin
        n_enabled   = r_enabled;
        n_armed     = r_armed;
        n_flight    = r_flight;
        n_security  = r_security;
        n_gen       = r_gen;
        n_deadline  = r_deadline;
        n_backoff   = r_backoff;
        n_attempts  = r_attempts;
        n_successes = r_successes;
        n_failures  = r_failures;
        n_cause     = r_cause;
        go          = 1'b0;
        status      = ST_OK;

        case (r_req.req_type)
            REQ_SET_EN: begin
                n_enabled = r_req.enable_on;
                if (!r_req.enable_on) begin
                    // Turn off: drop the arming, keep deadline and flight flag
                    n_security = '0;
                    n_armed    = 1'b0;
                    n_backoff  = '0;
                    n_cause    = CAUSE_OFF;
                end else if (!r_armed) begin
                    n_cause = CAUSE_WAIT_ARM;
                end
            end
            REQ_ARM: begin
                if (!r_enabled) begin
                    status = ST_REFUSED;
                end else begin
                    n_security = r_req.security_word;
                    n_gen      = r_req.module_gen;
                    n_deadline = r_req.now_ms;
                    n_backoff  = '0;
                    n_cause    = CAUSE_NONE;
                    n_armed    = 1'b1;
                end
            end
            REQ_DISARM: begin
                n_security = '0;
                n_armed    = 1'b0;
                n_backoff  = '0;
                n_cause    = CAUSE_DISARMED;
            end
            REQ_TRY: begin
                if (!r_armed) begin
                    status = ST_REFUSED;
                end else if (r_gen != r_req.module_gen) begin
                    // Module identity moved on: drop the stale arming
                    n_security = '0;
                    n_armed    = 1'b0;
                    n_backoff  = '0;
                    n_cause    = CAUSE_STALE;
                    status     = ST_REFUSED;
                end else begin
                    go = !since[WORD_W-1];
                end
            end
            REQ_START: begin
                if (!r_armed) begin
                    status = ST_REFUSED;
                end else begin
                    n_attempts = r_attempts + 1'b1;
                    n_flight   = 1'b1;
                    go         = 1'b1;
                end
            end
            REQ_DONE: begin
                n_flight = 1'b0;
                if (r_req.call_outcome == OUT_ABORTED) begin
                    status = ST_ABORTED;
                end else if (r_req.call_outcome == OUT_COMPLETED && r_req.join_ok) begin
                    n_successes = r_successes + 1'b1;
                    n_backoff   = '0;
                    n_deadline  = r_req.now_ms;
                    n_cause     = CAUSE_NONE;
                end else begin
                    // Error, unknown outcome or completed without a join
                    n_failures = r_failures + 1'b1;
                    n_backoff  = capped;
                    n_deadline = r_req.now_ms + {1'b0, capped};
                    status     = ST_FAILED;
                end
            end
            default: begin
                status = ST_REFUSED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b1;
            r_armed     <= 1'b0;
            r_flight    <= 1'b0;
            r_security  <= '0;
            r_gen       <= '0;
            r_deadline  <= '0;
            r_backoff   <= '0;
            r_attempts  <= '0;
            r_successes <= '0;
            r_failures  <= '0;
            r_cause     <= CAUSE_WAIT_ARM;
        end else if (adv) begin
            r_enabled   <= n_enabled;
            r_armed     <= n_armed;
            r_flight    <= n_flight;
            r_security  <= n_security;
            r_gen       <= n_gen;
            r_deadline  <= n_deadline;
            r_backoff   <= n_backoff;
            r_attempts  <= n_attempts;
            r_successes <= n_successes;
            r_failures  <= n_failures;
            r_cause     <= n_cause;
        end
    end

    // ------------------------------------------------------------------
    // Result register: capture the post-event view on every advance
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rsp.go            <= go;
            r_rsp.is_armed      <= n_armed;
            r_rsp.in_flight     <= n_flight;
            r_rsp.status        <= status;
            r_rsp.security_out  <= n_security;
            r_rsp.backoff_now   <= n_backoff;
            r_rsp.next_try_at   <= n_deadline;
            r_rsp.attempt_count <= n_attempts;
            r_rsp.success_count <= n_successes;
            r_rsp.failure_count <= n_failures;
            r_rsp.idle_cause    <= n_cause;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

`ifndef SYNTHESIS
    // A failed attempt never leaves the backoff above the ceiling
    a_backoff_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_req.req_type == REQ_DONE && status == ST_FAILED
        |=> r_backoff <= $past(r_max))
        else $error("backoff above ceiling after failure");

    // Security word is only held while armed
    a_security_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> r_security == '0)
        else $error("security word kept while not armed");

    // A granted result always reports the block as armed
    a_go_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_rsp.go |-> r_rsp.is_armed)
        else $error("go without arming");

    // A waiting event is not lost while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid && $stable(r_req))
        else $error("pending event dropped during stall");
`endif

endmodule
